FILE: rtl/mat_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and lexer tables for the mail address tokenizer.
// No dependencies; the design modules import this package.
package mat_pkg;

    localparam int BUF_BYTES   = 512;
    localparam int MAX_TOKENS  = 100;
    localparam int MAX_DEPTH   = 255;
    localparam int QUEUE_DEPTH = 4;

    // lexer states
    localparam logic [2:0] LX_OPR = 3'd0;
    localparam logic [2:0] LX_ATM = 3'd1;
    localparam logic [2:0] LX_QST = 3'd2;
    localparam logic [2:0] LX_SPC = 3'd3;
    localparam logic [2:0] LX_ONE = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // final status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_PAREN_BAL  = 4'd1;
    localparam logic [3:0] ST_ANGLE_BAL  = 4'd2;
    localparam logic [3:0] ST_TOO_LONG   = 4'd3;
    localparam logic [3:0] ST_TOO_MANY   = 4'd4;
    localparam logic [3:0] ST_PAREN_OPEN = 4'd5;
    localparam logic [3:0] ST_ANGLE_OPEN = 4'd6;
    localparam logic [3:0] ST_QUOTE_OPEN = 4'd7;
    localparam logic [3:0] ST_EMPTY      = 4'd8;

    // configuration register indexes
    localparam logic [2:0] REG_DELIM   = 3'd0;
    localparam logic [2:0] REG_OP_LO   = 3'd1;
    localparam logic [2:0] REG_OP_HI   = 3'd2;
    localparam logic [2:0] REG_CLASS   = 3'd3;
    localparam logic [2:0] REG_REPLACE = 3'd4;
    localparam logic [2:0] REG_NEGATED = 3'd5;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef struct packed {
        logic [6:0]  delimiter;
        logic [63:0] op_lo;
        logic [63:0] op_hi;
        logic [7:0]  class_match;
        logic [7:0]  replace;
        logic [7:0]  negated;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] token_byte;
        logic [3:0] status;
    } t_res;

    // results caused by one accepted byte, oldest in res[0]
    typedef struct packed {
        logic [1:0]       cnt;
        t_res [2:0]       res;
    } t_bundle;

    typedef struct packed {
        logic       brk;
        logic       meta;
        logic [2:0] st;
    } t_lex;

    function automatic t_res mk_res(logic [1:0] kind, logic [7:0] tb, logic [3:0] st);
        t_res r;
        r.kind       = kind;
        r.token_byte = tb;
        r.status     = st;
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c inside {CH_SPACE, [8'd9:8'd13]};
    endfunction

    function automatic logic [2:0] char_class(logic [7:0] c, t_cfg cfg);
        logic [2:0] cls;
        if (c == cfg.class_match || c == cfg.replace || c == cfg.negated) begin
            cls = LX_ONE;
        end else if (c == CH_QUOTE) begin
            cls = LX_QST;
        end else if (c[7]) begin
            cls = LX_ATM;
        end else if (is_blank(c) || c == CH_RPAREN) begin
            cls = LX_SPC;
        end else if (c < CH_SPACE || c == CH_DEL) begin
            cls = LX_OPR;
        end else if (c inside {CH_LPAREN, CH_LT, CH_GT, CH_COMMA, CH_SEMI, CH_BSL}) begin
            cls = LX_OPR;
        end else if (!c[6]) begin
            cls = cfg.op_lo[c[5:0]] ? LX_OPR : LX_ATM;
        end else begin
            cls = cfg.op_hi[c[5:0]] ? LX_OPR : LX_ATM;
        end
        return cls;
    endfunction

    // transition table: brk closes the open token, meta drops the character
    function automatic t_lex lex_next(logic [2:0] st, logic [2:0] cls);
        t_lex r;
        r = '{brk: 1'b0, meta: 1'b0, st: LX_OPR};
        case (st)
            LX_OPR, LX_ATM: begin
                r.brk = 1'b1;
                case (cls)
                    LX_ATM: begin
                        r.st  = LX_ATM;
                        r.brk = (st == LX_OPR);
                    end
                    LX_QST:  r.st = LX_QST;
                    LX_SPC: begin
                        r.st   = LX_SPC;
                        r.meta = 1'b1;
                    end
                    LX_ONE:  r.st = LX_ONE;
                    default: r.st = LX_OPR;
                endcase
            end
            LX_QST: begin
                r.st = (cls == LX_QST) ? LX_OPR : LX_QST;
            end
            LX_SPC: begin
                case (cls)
                    LX_ATM:  r.st = LX_ATM;
                    LX_QST:  r.st = LX_QST;
                    LX_SPC: begin
                        r.st   = LX_SPC;
                        r.meta = 1'b1;
                    end
                    LX_ONE:  r.st = LX_ONE;
                    default: r.st = LX_OPR;
                endcase
            end
            default: r.st = LX_OPR;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/mat_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the address byte input and the result output.
// Standalone; no package needed.
interface mat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface mat_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [3:0] status;
    logic       last;

    modport source (output valid, output kind, output token_byte, output status,
                    output last, input ready);
    modport sink (input valid, input kind, input token_byte, input status,
                  input last, output ready);
endinterface

FILE: rtl/mat_cfg.sv
`timescale 1ns / 1ps
// APB-style configuration registers: delimiter, operator bitmaps, meta characters.
// Depends on mat_pkg.
module mat_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [5:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    output mat_pkg::t_cfg  o_cfg
);
    import mat_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[5:3];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter   <= 7'd0;
            r_cfg.op_lo       <= 64'd0;
            r_cfg.op_hi       <= 64'd0;
            r_cfg.class_match <= 8'd18;
            r_cfg.replace     <= 8'd21;
            r_cfg.negated     <= 8'd19;
        end else if (w_wr) begin
            case (w_idx)
                REG_DELIM:   r_cfg.delimiter   <= pwdata[6:0];
                REG_OP_LO:   r_cfg.op_lo       <= pwdata;
                REG_OP_HI:   r_cfg.op_hi       <= pwdata;
                REG_CLASS:   r_cfg.class_match <= pwdata[7:0];
                REG_REPLACE: r_cfg.replace     <= pwdata[7:0];
                REG_NEGATED: r_cfg.negated     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DELIM:   prdata = {57'd0, r_cfg.delimiter};
            REG_OP_LO:   prdata = r_cfg.op_lo;
            REG_OP_HI:   prdata = r_cfg.op_hi;
            REG_CLASS:   prdata = {56'd0, r_cfg.class_match};
            REG_REPLACE: prdata = {56'd0, r_cfg.replace};
            REG_NEGATED: prdata = {56'd0, r_cfg.negated};
            default:     prdata = 64'd0;
        endcase
    end

endmodule

FILE: rtl/mat_front.sv
`timescale 1ns / 1ps
// Front end: accepts one address byte a cycle while the queue has space, runs the lexer
// and depth and length counters, packs its results in one bundle. Depends on mat_pkg.
module mat_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mat_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_space,
    output logic             o_ready,
    output logic             o_push,
    output mat_pkg::t_bundle o_bundle
);
    import mat_pkg::*;

    localparam logic [9:0] BYTES_LIM = 10'(BUF_BYTES - 5);
    localparam logic [9:0] BYTES_SAT = 10'd1023;
    localparam logic [6:0] TOK_LIM   = 7'(MAX_TOKENS);
    localparam logic [7:0] DEPTH_LIM = 8'(MAX_DEPTH);

    logic [2:0] r_lex,      n_lex;
    logic       r_esc,      n_esc;
    logic [7:0] r_cdep,     n_cdep;
    logic [7:0] r_adep,     n_adep;
    logic       r_look_vld, n_look_vld;
    logic [7:0] r_look,     n_look;
    logic [9:0] r_bytes,    n_bytes;
    logic [6:0] r_toks,     n_toks;
    logic       r_topen,    n_topen;
    logic       r_skip,     n_skip;

    logic       w_acc;

    assign o_ready = i_space;
    assign w_acc   = i_valid & i_space;

    always_comb begin
        t_bundle    v_bun;
        logic [1:0] v_cnt;
        logic [7:0] v_c;
        logic       v_done;
        logic       v_have;
        logic       v_fail;
        logic [3:0] v_code;
        logic       v_clear;
        logic       v_skip_set;
        logic       v_close;
        logic       v_final;
        logic       v_skip_after;
        logic       v_set_look;
        t_lex       v_lex;

        n_lex      = r_lex;
        n_esc      = r_esc;
        n_cdep     = r_cdep;
        n_adep     = r_adep;
        n_look_vld = r_look_vld;
        n_look     = r_look;
        n_bytes    = r_bytes;
        n_toks     = r_toks;
        n_topen    = r_topen;
        n_skip     = r_skip;

        v_bun        = '0;
        v_cnt        = 2'd0;
        v_c          = {1'b0, i_byte[6:0]};
        v_done       = 1'b0;
        v_have       = 1'b1;
        v_fail       = 1'b0;
        v_code       = ST_OK;
        v_clear      = 1'b0;
        v_skip_set   = 1'b0;
        v_close      = 1'b0;
        v_final      = 1'b0;
        v_skip_after = 1'b0;
        v_set_look   = 1'b0;
        v_lex        = '0;

        if (w_acc) begin
            // drop everything up to and including the next zero byte
            if (r_skip) begin
                if (i_byte == CH_NUL) begin
                    v_clear = 1'b1;
                end
                v_done = 1'b1;
            end

            // flush the held character before looking at the new one
            if (!v_done && r_look_vld) begin
                if (r_bytes >= BYTES_LIM) begin
                    v_fail     = 1'b1;
                    v_code     = ST_TOO_LONG;
                    v_skip_set = (i_byte != CH_NUL);
                    v_done     = 1'b1;
                end else begin
                    v_bun.res[v_cnt] = mk_res(KIND_BYTE, r_look, ST_OK);
                    v_cnt            = v_cnt + 2'd1;
                    n_bytes          = r_bytes + 10'd1;
                    n_topen          = 1'b1;
                    n_look_vld       = 1'b0;
                end
            end

            if (!v_done) begin
                if (i_byte == CH_NUL) begin
                    v_close      = 1'b1;
                    v_final      = 1'b1;
                    v_skip_after = 1'b0;
                end else begin
                    if (r_esc) begin
                        if (v_c != CH_BANG) begin
                            v_c[7] = 1'b1;
                        end
                        n_esc = 1'b0;
                    end else if (v_c == CH_BSL) begin
                        n_esc  = 1'b1;
                        v_have = 1'b0;
                    end else if (r_lex == LX_QST) begin
                        v_have = 1'b1;
                    end else if (v_c == CH_LPAREN) begin
                        if (r_cdep >= DEPTH_LIM) begin
                            v_fail = 1'b1;
                            v_code = ST_EMPTY;
                        end else begin
                            n_cdep = r_cdep + 8'd1;
                            v_have = 1'b0;
                        end
                    end else if (v_c == CH_RPAREN) begin
                        if (r_cdep == 8'd0) begin
                            v_fail = 1'b1;
                            v_code = ST_PAREN_BAL;
                        end else begin
                            n_cdep = r_cdep - 8'd1;
                        end
                    end else if (r_cdep != 8'd0) begin
                        v_have = 1'b0;
                    end else if (v_c == CH_LT) begin
                        if (r_adep >= DEPTH_LIM) begin
                            v_fail = 1'b1;
                            v_code = ST_EMPTY;
                        end else begin
                            n_adep = r_adep + 8'd1;
                        end
                    end else if (v_c == CH_GT) begin
                        if (r_adep == 8'd0) begin
                            v_fail = 1'b1;
                            v_code = ST_ANGLE_BAL;
                        end else begin
                            n_adep = r_adep - 8'd1;
                        end
                    end else if ({1'b0, i_cfg.delimiter} == CH_SPACE && is_blank(v_c)) begin
                        v_c = CH_SPACE;
                    end

                    if (v_fail) begin
                        v_skip_set = 1'b1;
                        v_done     = 1'b1;
                    end

                    if (!v_done && v_have) begin
                        v_skip_after = 1'b1;
                        if (v_c == {1'b0, i_cfg.delimiter} && n_adep == 8'd0 &&
                            r_lex != LX_QST) begin
                            v_close = 1'b1;
                            v_final = 1'b1;
                        end else begin
                            v_lex = lex_next(r_lex, char_class(v_c, i_cfg));
                            n_lex = v_lex.st;
                            if (v_lex.meta) begin
                                v_have = 1'b0;
                            end
                            v_close    = v_lex.brk;
                            v_set_look = v_have;
                        end
                    end
                end
            end

            // close the open token
            if (v_close && n_topen) begin
                if (r_toks >= TOK_LIM) begin
                    v_fail     = 1'b1;
                    v_code     = ST_TOO_MANY;
                    v_skip_set = v_skip_after;
                    v_final    = 1'b0;
                    v_set_look = 1'b0;
                end else begin
                    n_toks  = r_toks + 7'd1;
                    if (n_bytes < BYTES_SAT) begin
                        n_bytes = n_bytes + 10'd1;
                    end
                    n_topen          = 1'b0;
                    v_bun.res[v_cnt] = mk_res(KIND_END, 8'd0, ST_OK);
                    v_cnt            = v_cnt + 2'd1;
                end
            end

            if (v_final) begin
                if (n_cdep != 8'd0) begin
                    v_code = ST_PAREN_OPEN;
                end else if (n_adep != 8'd0) begin
                    v_code = ST_ANGLE_OPEN;
                end else if (n_lex == LX_QST) begin
                    v_code = ST_QUOTE_OPEN;
                end else if (n_toks != 7'd0) begin
                    v_code = ST_OK;
                end else begin
                    v_code = ST_EMPTY;
                end
                v_bun.res[v_cnt] = mk_res(KIND_STATUS, 8'd0, v_code);
                v_cnt            = v_cnt + 2'd1;
                v_clear          = 1'b1;
                v_skip_set       = v_skip_after;
            end

            if (v_fail) begin
                v_bun.res[v_cnt] = mk_res(KIND_STATUS, 8'd0, v_code);
                v_cnt            = v_cnt + 2'd1;
                v_clear          = 1'b1;
            end

            if (v_set_look) begin
                n_look     = v_c;
                n_look_vld = 1'b1;
            end

            if (v_clear) begin
                n_lex      = LX_OPR;
                n_esc      = 1'b0;
                n_cdep     = 8'd0;
                n_adep     = 8'd0;
                n_look_vld = 1'b0;
                n_look     = 8'd0;
                n_bytes    = 10'd0;
                n_toks     = 7'd0;
                n_topen    = 1'b0;
                n_skip     = v_skip_set;
            end
        end

        v_bun.cnt = v_cnt;
        o_bundle  = v_bun;
        o_push    = (v_cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex      <= LX_OPR;
            r_esc      <= 1'b0;
            r_cdep     <= 8'd0;
            r_adep     <= 8'd0;
            r_look_vld <= 1'b0;
            r_bytes    <= 10'd0;
            r_toks     <= 7'd0;
            r_topen    <= 1'b0;
            r_skip     <= 1'b0;
        end else begin
            r_lex      <= n_lex;
            r_esc      <= n_esc;
            r_cdep     <= n_cdep;
            r_adep     <= n_adep;
            r_look_vld <= n_look_vld;
            r_bytes    <= n_bytes;
            r_toks     <= n_toks;
            r_topen    <= n_topen;
            r_skip     <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_look <= n_look;
    end

endmodule

FILE: rtl/mat_back.sv
`timescale 1ns / 1ps
// Back end: a short queue of result bundles, drained one result a cycle onto the output
// channel while ready, and marks each bundle's final result last. Depends on mat_pkg.
module mat_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mat_pkg::t_bundle i_bundle,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output mat_pkg::t_res    o_res,
    output logic             o_last
);
    import mat_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QW-1:0] PTR_MAX = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(QUEUE_DEPTH);

    t_bundle       r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wr,  n_wr;
    logic [QW-1:0] r_rd,  n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_idx, n_idx;

    t_bundle       w_head;
    logic          w_push;
    logic          w_pop;
    logic          w_take;

    assign w_head  = r_mem[r_rd];
    assign o_space = (r_cnt < CNT_MAX);
    assign o_valid = (r_cnt != '0);
    assign o_res   = w_head.res[r_idx];
    assign o_last  = (r_idx == w_head.cnt - 2'd1);
    assign w_take  = o_valid & i_ready;
    assign w_pop   = w_take & o_last;
    assign w_push  = i_push & o_space;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_idx = r_idx;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PTR_MAX) ? '0 : r_wr + QW'(1);
        end
        if (w_take) begin
            // advance within the bundle, release it on its last result
            if (o_last) begin
                n_idx = 2'd0;
                n_rd  = (r_rd == PTR_MAX) ? '0 : r_rd + QW'(1);
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_idx <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

endmodule

FILE: rtl/mail_address_tokenizer.sv
`timescale 1ns / 1ps
// Mail address tokenizer, top level. Depends on mat_pkg, mat_if, mat_cfg, mat_front, mat_back.
// The results of an accepted byte are registered in the queue and offered from its head.
// Throughput: one byte per cycle while the queue has space; a byte's results leave one at
// a time through the single output port, and a four-bundle queue absorbs the bursts.
// Reset: synchronous, active low; clears the lexer state, the queue and the config registers.
module mail_address_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    mat_in_if.sink      i_in,
    mat_out_if.source   o_out
);
    import mat_pkg::*;

    t_cfg    w_cfg;
    t_bundle w_bundle;
    t_res    w_res;
    logic    w_push;
    logic    w_space;

    mat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mat_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_in.valid),
        .i_byte   (i_in.in_byte),
        .i_space  (w_space),
        .o_ready  (i_in.ready),
        .o_push   (w_push),
        .o_bundle (w_bundle)
    );

    mat_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_bundle),
        .o_space  (w_space),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_res    (w_res),
        .o_last   (o_out.last)
    );

    assign o_out.kind       = w_res.kind;
    assign o_out.token_byte = w_res.token_byte;
    assign o_out.status     = w_res.status;

endmodule
